### rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared constants, calibration table and state encoding for the pulse count
// to temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  localparam int COUNT_W   = 12;
  localparam int TEMP_W    = 17;
  localparam int FLAG_W    = 2;

  localparam int LUT_SIZE      = 21;
  localparam int TABLE_POINTS  = 21;
  localparam int FRACTION_BITS = 8;

  // points actually used, limited to the table and to at least two
  localparam int USED_POINTS = (TABLE_POINTS > LUT_SIZE) ? LUT_SIZE :
                               (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;

  localparam int ROW_W = $clog2(LUT_SIZE);

  // neighbouring table temperatures differ by at most 15 degrees
  localparam int STEP_W = 4;

  // step * (count - low count), then shifted up by the fraction bits
  localparam int MUL_W   = COUNT_W + STEP_W;
  localparam int NUM_W   = MUL_W + FRACTION_BITS;
  localparam int QUO_W   = FRACTION_BITS + STEP_W;
  localparam int BITCNT_W = $clog2(NUM_W);

  localparam logic [FLAG_W-1:0] FLAG_IN_RANGE = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_LOW      = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_HIGH     = 2'd2;

  localparam logic [COUNT_W-1:0] LUT_COUNT [LUT_SIZE] = '{
    12'd26,   12'd181,  12'd338,  12'd494,  12'd651,  12'd808,  12'd966,
    12'd1125, 12'd1284, 12'd1443, 12'd1602, 12'd1762, 12'd1923, 12'd2084,
    12'd2245, 12'd2407, 12'd2569, 12'd2731, 12'd2893, 12'd3057, 12'd3218
  };

  localparam int LUT_TEMP [LUT_SIZE] = '{
    -50, -40, -30, -20, -10, 0, 10, 20, 30, 40, 50,
    60, 70, 80, 90, 100, 110, 120, 130, 140, 150
  };

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(USED_POINTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  function automatic logic [TEMP_W-1:0] to_fixed(input int whole);
    int scaled;
    scaled = whole * (1 << FRACTION_BITS);
    return TEMP_W'(scaled);
  endfunction

  localparam logic [TEMP_W-1:0] TEMP_LOW_FIXED  = to_fixed(LUT_TEMP[0]);
  localparam logic [TEMP_W-1:0] TEMP_HIGH_FIXED = to_fixed(LUT_TEMP[USED_POINTS-1]);

endpackage

`default_nettype wire

### rtl/core/pct_if.sv
// ----------------------------------------------------------------------------
// pct_if
// Valid/ready channels for pulse count samples and temperature results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pct_sample_if
  import pct_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] pulse_count;

  modport source (output valid, output pulse_count, input ready);
  modport sink   (input valid, input pulse_count, output ready);
endinterface

interface pct_result_if
  import pct_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_q8;
  logic [FLAG_W-1:0]        range_flag;

  modport source (output valid, output temperature_q8, output range_flag, input ready);
  modport sink   (input valid, input temperature_q8, input range_flag, output ready);
endinterface

`default_nettype wire

### rtl/core/pulse_count_to_temperature.sv
// ----------------------------------------------------------------------------
// pulse_count_to_temperature
// Linearizes a sensor pulse count through a calibration table by a row search,
// a multiply and a bit-serial restoring division; clamps counts off the table.
// ----------------------------------------------------------------------------
// sequence: a clamped count, or one equal to the first table count, goes from
//   idle straight to the finish state; any other count passes through the
//   one-row-per-cycle search, the multiply state and the one quotient bit
//   per cycle divider before it reaches the finish state
// samples: a new sample is taken only once the last result has reached the
//   output register, and may be taken while that result still waits there
// reset: rst (synchronous) returns to idle and drops result valid
`default_nettype none

module pulse_count_to_temperature
  import pct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  pct_sample_if.sink      sample,
  pct_result_if.source    result
);

  state_t               state, state_next;
  logic [COUNT_W-1:0]   pcount, pcount_next;
  logic [ROW_W-1:0]     row, row_next;
  logic [COUNT_W-1:0]   span, span_next;
  logic [TEMP_W-1:0]    base, base_next;
  logic [NUM_W-1:0]     num_sr, num_sr_next;
  logic [COUNT_W-1:0]   rem, rem_next;
  logic [QUO_W-1:0]     quo, quo_next;
  logic [BITCNT_W-1:0]  bit_cnt, bit_cnt_next;
  logic [FLAG_W-1:0]    flag, flag_next;
  logic                 out_valid, out_valid_next;
  logic [TEMP_W-1:0]    out_temp, out_temp_next;
  logic [FLAG_W-1:0]    out_flag, out_flag_next;

  logic [ROW_W-1:0]     row_prev;
  logic [COUNT_W-1:0]   c_lo, c_hi, diff;
  logic [STEP_W-1:0]    step;
  logic [MUL_W-1:0]     prod;
  logic [COUNT_W:0]     trial;
  logic                 fits;

  assign sample.ready          = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.temperature_q8 = out_temp;
  assign result.range_flag     = out_flag;

  always_comb begin
    row_prev = ROW_W'(row - 1'b1);
    c_lo     = LUT_COUNT[row_prev];
    c_hi     = LUT_COUNT[row];
    diff     = pcount - c_lo;
    step     = STEP_W'(LUT_TEMP[row] - LUT_TEMP[row_prev]);
    prod     = MUL_W'(step) * MUL_W'(diff);
    trial    = {rem, num_sr[NUM_W-1]};
    fits     = (trial >= {1'b0, span});
  end

  always_comb begin
    state_next     = state;
    pcount_next    = pcount;
    row_next       = row;
    span_next      = span;
    base_next      = base;
    num_sr_next    = num_sr;
    rem_next       = rem;
    quo_next       = quo;
    bit_cnt_next   = bit_cnt;
    flag_next      = flag;
    out_valid_next = out_valid;
    out_temp_next  = out_temp;
    out_flag_next  = out_flag;

    if (result.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (sample.valid) begin
          pcount_next = sample.pulse_count;
          quo_next    = '0;
          row_next    = ROW_W'(1);
          flag_next   = FLAG_IN_RANGE;
          if (sample.pulse_count < LUT_COUNT[0]) begin
            base_next  = TEMP_LOW_FIXED;
            flag_next  = FLAG_LOW;
            state_next = S_FINISH;
          end else if (sample.pulse_count > LUT_COUNT[LAST_ROW]) begin
            base_next  = TEMP_HIGH_FIXED;
            flag_next  = FLAG_HIGH;
            state_next = S_FINISH;
          end else if (sample.pulse_count == LUT_COUNT[0]) begin
            base_next  = TEMP_LOW_FIXED;
            state_next = S_FINISH;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // first row whose count reaches the sample, last row at most
        if (row < LAST_ROW && c_hi < pcount) begin
          row_next = ROW_W'(row + 1'b1);
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        span_next    = c_hi - c_lo;
        base_next    = to_fixed(LUT_TEMP[row_prev]);
        num_sr_next  = NUM_W'(prod) << FRACTION_BITS;
        rem_next     = '0;
        quo_next     = '0;
        bit_cnt_next = BITCNT_W'(NUM_W - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        rem_next    = fits ? COUNT_W'(trial - {1'b0, span}) : COUNT_W'(trial);
        quo_next    = {quo[QUO_W-2:0], fits};
        num_sr_next = {num_sr[NUM_W-2:0], 1'b0};
        bit_cnt_next = BITCNT_W'(bit_cnt - 1'b1);
        if (bit_cnt == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hand over once the output register is free or being emptied
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          out_temp_next  = base + TEMP_W'(quo);
          out_flag_next  = flag;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pcount   <= pcount_next;
    row      <= row_next;
    span     <= span_next;
    base     <= base_next;
    num_sr   <= num_sr_next;
    rem      <= rem_next;
    quo      <= quo_next;
    bit_cnt  <= bit_cnt_next;
    flag     <= flag_next;
    out_temp <= out_temp_next;
    out_flag <= out_flag_next;
  end

`ifndef SYNTHESIS
  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_flag == FLAG_IN_RANGE || out_flag == FLAG_LOW ||
                   out_flag == FLAG_HIGH))
    else $error("result carries an unused range flag code");

  a_low_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_flag == FLAG_LOW) |-> (out_temp == TEMP_LOW_FIXED))
    else $error("low clamp result is not the first table temperature");

  a_high_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_flag == FLAG_HIGH) |-> (out_temp == TEMP_HIGH_FIXED))
    else $error("high clamp result is not the last table temperature");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < span))
    else $error("divider remainder reached the span");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state != S_IDLE))
    else $error("sample transfer did not start a conversion");
`endif

endmodule

`default_nettype wire
